@@ hw/rtl/bec_pkg.sv @@
`default_nettype none
package bec_pkg;

  // bond modes
  localparam logic [1:0] MODE_CENTRE = 2'd0;
  localparam logic [1:0] MODE_PLANE  = 2'd1;

  // field widths
  localparam int COORD_W = 32;
  localparam int SIZE_W  = 16;
  localparam int DIFF_W  = 33;
  localparam int MAG_W   = 32;
  localparam int SQ_W    = 66;
  localparam int LEN_W   = 34;
  localparam int RAD_W   = 23;
  localparam int SUM_W   = 24;

  // quotient width of the shrink and trim dividers: a shrunk radius and a
  // trim offset never exceed the radius they come from
  localparam int QUO_W   = RAD_W;

  // square root steps and divider steps
  localparam int SQRT_STEPS = 34;
  localparam int DIV_STEPS  = QUO_W;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;
    logic [SIZE_W-1:0]         first_size;
    logic [SIZE_W-1:0]         second_size;
  } bond_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } bond_out_t;

  // radius in Q16.16: round(size * 102.4) = (size * 512 + 2) / 5
  function automatic logic [RAD_W-1:0] radius_of(input logic [SIZE_W-1:0] size);
    logic [27:0] num;
    logic [55:0] prod;
    begin
      num  = {3'b0, size, 9'b0} + 28'd2;
      // divide by 5: multiply by ceil(2^26/5) then shift, exact for num < 2^26
      prod = {28'b0, num} * 56'd13421773;
      radius_of = prod[26 +: RAD_W];
    end
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bec_if.sv @@
`default_nettype none
interface bec_in_if;
  import bec_pkg::*;
  logic     valid;
  logic     ready;
  bond_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bec_out_if;
  import bec_pkg::*;
  logic      valid;
  logic      ready;
  bond_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/bec_sqrt.sv @@
`default_nettype none
// pipelined restoring square root, one result bit per stage
module bec_sqrt #(
  parameter int STEPS = bec_pkg::SQRT_STEPS
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [2*STEPS-1:0]       rad,
  output logic      [STEPS-1:0]         root
);
  import bec_pkg::*;

  localparam int RW = STEPS + 2;

  logic [2*STEPS-1:0] rad_r [STEPS];
  logic [RW-1:0]      rem_r [STEPS];
  logic [STEPS-1:0]   q_r   [STEPS];

  genvar g;
  generate
    for (g = 0; g < STEPS; g++) begin : g_stage
      logic [2*STEPS-1:0] rad_in;
      logic [RW-1:0]      rem_in;
      logic [STEPS-1:0]   q_in;
      logic [RW-1:0]      shifted;
      if (g == 0) begin : g_first
        assign rad_in = rad;
        assign rem_in = '0;
        assign q_in   = '0;
      end else begin : g_next
        assign rad_in = rad_r[g-1];
        assign rem_in = rem_r[g-1];
        assign q_in   = q_r[g-1];
      end
      // bring down two bits, try 4q+1
      assign shifted = {rem_in[RW-3:0], rad_in[2*STEPS-1 -: 2]};
      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[g] <= {rad_in[2*STEPS-3:0], 2'b00};
          if (shifted >= {q_in, 2'b01}) begin
            rem_r[g] <= shifted - {q_in, 2'b01};
            q_r[g]   <= {q_in[STEPS-2:0], 1'b1};
          end else begin
            rem_r[g] <= shifted;
            q_r[g]   <= {q_in[STEPS-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign root = q_r[STEPS-1];

endmodule
`default_nettype wire

@@ hw/rtl/bec_div.sv @@
`default_nettype none
// pipelined restoring divider, one quotient bit per stage
// the numerator bits above the low STEPS bits form the first partial
// remainder, so they must stay below den for the quotient to fit STEPS bits
module bec_div #(
  parameter int NW    = bec_pkg::RAD_W + bec_pkg::SUM_W,
  parameter int DW    = bec_pkg::SUM_W,
  parameter int STEPS = bec_pkg::DIV_STEPS
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NW-1:0]    num,
  input  wire logic [DW-1:0]    den,
  output logic      [STEPS-1:0] quo
);
  import bec_pkg::*;

  logic [STEPS-1:0] low_r [STEPS];
  logic [DW-1:0]    den_r [STEPS];
  logic [DW-1:0]    rem_r [STEPS];
  logic [STEPS-1:0] q_r   [STEPS];

  genvar g;
  generate
    for (g = 0; g < STEPS; g++) begin : g_stage
      logic [STEPS-1:0] low_in;
      logic [DW-1:0]    den_in;
      logic [DW-1:0]    rem_in;
      logic [STEPS-1:0] q_in;
      logic [DW:0]      sh;
      if (g == 0) begin : g_first
        assign low_in = num[STEPS-1:0];
        assign den_in = den;
        assign rem_in = DW'(num[NW-1:STEPS]);
        assign q_in   = '0;
      end else begin : g_next
        assign low_in = low_r[g-1];
        assign den_in = den_r[g-1];
        assign rem_in = rem_r[g-1];
        assign q_in   = q_r[g-1];
      end
      // bring down the next numerator bit, msb first
      assign sh = {rem_in, low_in[STEPS-1]};
      always_ff @(posedge clk) begin
        if (en) begin
          low_r[g] <= {low_in[STEPS-2:0], 1'b0};
          den_r[g] <= den_in;
          if (sh >= {1'b0, den_in}) begin
            rem_r[g] <= DW'(sh - {1'b0, den_in});
            q_r[g]   <= {q_in[STEPS-2:0], 1'b1};
          end else begin
            rem_r[g] <= sh[DW-1:0];
            q_r[g]   <= {q_in[STEPS-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign quo = q_r[STEPS-1];

endmodule
`default_nettype wire

@@ hw/rtl/bond_endpoint_clipper_core.sv @@
`default_nettype none
// bond endpoint clipper
// input channel in_* carries one bond per transaction: two atom centres
// (signed Q16.16 x/y/z) and two atom sizes (unsigned Q8.8). output channel
// out_* carries the four screen coordinates of the trimmed bond.
// cfg_we/cfg_wdata write the bond mode: 0 centre to centre, 1 trim in the
// screen plane, 2 (and 3) trim in 3D then drop z. write it only when idle.
// throughput: one bond per cycle while out_ready does not hold the pipe. between
// an input transaction and its output transaction lie the difference and the
// square and sum stages, 34 square root stages (one root bit each), the shrink
// setup stage, 23 shrink divider stages, the trim setup stage, 23 trim divider
// stages (one quotient bit each of both dividers) and the output register stage.
// all stages advance together on a single enable; when the receiver stalls
// the whole pipe holds, so nothing is lost or repeated, and in_ready follows
// out_ready whenever the output register is occupied.
// reset clears the valid bits of every stage and the mode to 0; data
// registers are not reset.
module bond_endpoint_clipper_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  bec_in_if.sink          in_ch,
  bec_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata
);
  import bec_pkg::*;

  // latency of stage groups
  localparam int L_SQ   = 2;               // diffs, squares+sum
  localparam int L_SQRT = SQRT_STEPS;
  localparam int L_SHR  = DIV_STEPS;
  localparam int L_TRIM = DIV_STEPS;
  localparam int LAT    = L_SQ + L_SQRT + 1 + L_SHR + 1 + L_TRIM + 1;

  logic [1:0] mode_r;
  logic [LAT-1:0] vld_r;
  logic en;

  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= MODE_CENTRE;
    else if (cfg_we) mode_r <= cfg_wdata;
  end

  // pipe advances unless the output holds an untaken result
  assign en = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_ch.valid};
  end

  // item context carried down the pipe
  typedef struct packed {
    bond_in_t   b;
    logic       clip;
  } ctx_t;

  // stage 1: differences and radii
  ctx_t ctx1_r;
  logic signed [DIFF_W-1:0] dx1_r, dy1_r, dz1_r;
  logic [RAD_W-1:0] ra1_r, rb1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ctx1_r.b    <= in_ch.data;
      ctx1_r.clip <= (mode_r != MODE_CENTRE);
      dx1_r <= DIFF_W'(in_ch.data.second_x) - DIFF_W'(in_ch.data.first_x);
      dy1_r <= DIFF_W'(in_ch.data.second_y) - DIFF_W'(in_ch.data.first_y);
      dz1_r <= (mode_r == MODE_PLANE) ? '0 :
               DIFF_W'(in_ch.data.second_z) - DIFF_W'(in_ch.data.first_z);
      ra1_r <= radius_of(in_ch.data.first_size);
      rb1_r <= radius_of(in_ch.data.second_size);
    end
  end

  // stage 2: squares of magnitudes and their sum
  logic [MAG_W-1:0] mx, my, mz;
  assign mx = dx1_r[DIFF_W-1] ? MAG_W'(-dx1_r) : MAG_W'(dx1_r);
  assign my = dy1_r[DIFF_W-1] ? MAG_W'(-dy1_r) : MAG_W'(dy1_r);
  assign mz = dz1_r[DIFF_W-1] ? MAG_W'(-dz1_r) : MAG_W'(dz1_r);
  logic [SQ_W-1:0] ss2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ss2_r <= SQ_W'({32'b0, mx} * {32'b0, mx}) + SQ_W'({32'b0, my} * {32'b0, my})
             + SQ_W'({32'b0, mz} * {32'b0, mz});
    end
  end

  // carry context alongside sqrt
  localparam int CW = $bits(ctx_t) + 3*DIFF_W + 2*RAD_W;
  logic [CW-1:0] c_q1 [L_SQRT+1];
  logic [CW-1:0] c_in1;
  ctx_t ctx2_r;
  logic signed [DIFF_W-1:0] dx2_r, dy2_r, dz2_r;
  logic [RAD_W-1:0] ra2_r, rb2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ctx2_r <= ctx1_r; dx2_r <= dx1_r; dy2_r <= dy1_r; dz2_r <= dz1_r;
      ra2_r <= ra1_r; rb2_r <= rb1_r;
    end
  end
  assign c_in1 = {ctx2_r, dx2_r, dy2_r, dz2_r, ra2_r, rb2_r};
  assign c_q1[0] = c_in1;

  logic [LEN_W-1:0] root;
  bec_sqrt #(.STEPS(SQRT_STEPS)) u_sqrt (
    .clk(clk), .en(en), .rad({2'b00, ss2_r}), .root(root)
  );

  genvar g;
  generate
    for (g = 0; g < L_SQRT; g++) begin : g_c1
      logic [CW-1:0] hold_r;
      always_ff @(posedge clk) if (en) hold_r <= c_q1[g];
      assign c_q1[g+1] = hold_r;
    end
  endgenerate

  // stage s: length known; flag shrink, prepare radii sum
  ctx_t ctx3; logic signed [DIFF_W-1:0] dx3, dy3, dz3; logic [RAD_W-1:0] ra3, rb3;
  assign {ctx3, dx3, dy3, dz3, ra3, rb3} = c_q1[L_SQRT];
  ctx_t ctx4_r;
  logic signed [DIFF_W-1:0] dx4_r, dy4_r;
  logic [RAD_W-1:0] ra4_r, rb4_r;
  logic [LEN_W-1:0] len4_r;
  logic [SUM_W-1:0] sum4_r;
  logic shrink4_r, zero4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ctx4_r <= ctx3; dx4_r <= dx3; dy4_r <= dy3;
      ra4_r <= ra3; rb4_r <= rb3;
      len4_r <= (root == '0) ? LEN_W'(1) : root;
      zero4_r <= (dx3 == '0) && (dy3 == '0) && (dz3 == '0);
      sum4_r <= SUM_W'(ra3) + SUM_W'(rb3);
      shrink4_r <= ({{(LEN_W-SUM_W){1'b0}}, SUM_W'(ra3) + SUM_W'(rb3)} > root);
    end
  end

  // shrink dividers: ra*len/sum, rb*len/sum; a shrink only happens with the
  // root below sum, so len is at most sum and its low SUM_W bits carry all of it
  localparam int PW = RAD_W + SUM_W;
  logic [PW-1:0] pa, pb;
  assign pa = PW'(ra4_r) * PW'(len4_r[SUM_W-1:0]);
  assign pb = PW'(rb4_r) * PW'(len4_r[SUM_W-1:0]);
  logic [DIV_STEPS-1:0] qa, qb;
  bec_div #(.NW(PW), .DW(SUM_W), .STEPS(DIV_STEPS)) u_shr_a (
    .clk(clk), .en(en), .num(pa), .den(sum4_r), .quo(qa)
  );
  bec_div #(.NW(PW), .DW(SUM_W), .STEPS(DIV_STEPS)) u_shr_b (
    .clk(clk), .en(en), .num(pb), .den(sum4_r), .quo(qb)
  );

  localparam int CW2 = $bits(ctx_t) + 2*DIFF_W + 2*RAD_W + LEN_W + 2;
  logic [CW2-1:0] c_q2 [L_SHR+1];
  assign c_q2[0] = {ctx4_r, dx4_r, dy4_r, ra4_r, rb4_r, len4_r, shrink4_r, zero4_r};
  generate
    for (g = 0; g < L_SHR; g++) begin : g_c2
      logic [CW2-1:0] hold_r;
      always_ff @(posedge clk) if (en) hold_r <= c_q2[g];
      assign c_q2[g+1] = hold_r;
    end
  endgenerate

  ctx_t ctx5; logic signed [DIFF_W-1:0] dx5, dy5; logic [RAD_W-1:0] ra5, rb5;
  logic [LEN_W-1:0] len5; logic shr5, zero5;
  assign {ctx5, dx5, dy5, ra5, rb5, len5, shr5, zero5} = c_q2[L_SHR];

  // stage t: final radii, form trim numerators r*|d| + len/2
  ctx_t ctx6_r;
  logic signed [DIFF_W-1:0] dx6_r, dy6_r;
  logic [RAD_W-1:0] fa6_r, fb6_r;
  logic [LEN_W-1:0] len6_r;
  logic zero6_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ctx6_r <= ctx5; dx6_r <= dx5; dy6_r <= dy5; len6_r <= len5; zero6_r <= zero5;
      fa6_r <= shr5 ? RAD_W'(qa) : ra5;
      fb6_r <= shr5 ? RAD_W'(qb) : rb5;
    end
  end

  logic [MAG_W-1:0] ax6, ay6;
  assign ax6 = dx6_r[DIFF_W-1] ? MAG_W'(-dx6_r) : MAG_W'(dx6_r);
  assign ay6 = dy6_r[DIFF_W-1] ? MAG_W'(-dy6_r) : MAG_W'(dy6_r);
  localparam int TW = RAD_W + MAG_W + 1;
  logic [TW-1:0] nax, nay, nbx, nby;
  logic [TW-1:0] half;
  assign half = TW'(len6_r >> 1);
  assign nax = TW'(fa6_r) * TW'(ax6) + half;
  assign nay = TW'(fa6_r) * TW'(ay6) + half;
  assign nbx = TW'(fb6_r) * TW'(ax6) + half;
  assign nby = TW'(fb6_r) * TW'(ay6) + half;

  logic [DIV_STEPS-1:0] oax, oay, obx, oby;
  bec_div #(.NW(TW), .DW(LEN_W), .STEPS(DIV_STEPS)) u_tax (
    .clk(clk), .en(en), .num(nax), .den(len6_r), .quo(oax));
  bec_div #(.NW(TW), .DW(LEN_W), .STEPS(DIV_STEPS)) u_tay (
    .clk(clk), .en(en), .num(nay), .den(len6_r), .quo(oay));
  bec_div #(.NW(TW), .DW(LEN_W), .STEPS(DIV_STEPS)) u_tbx (
    .clk(clk), .en(en), .num(nbx), .den(len6_r), .quo(obx));
  bec_div #(.NW(TW), .DW(LEN_W), .STEPS(DIV_STEPS)) u_tby (
    .clk(clk), .en(en), .num(nby), .den(len6_r), .quo(oby));

  localparam int CW3 = $bits(ctx_t) + 2 + 1;
  logic [CW3-1:0] c_q3 [L_TRIM+1];
  assign c_q3[0] = {ctx6_r, dx6_r[DIFF_W-1], dy6_r[DIFF_W-1], zero6_r};
  generate
    for (g = 0; g < L_TRIM; g++) begin : g_c3
      logic [CW3-1:0] hold_r;
      always_ff @(posedge clk) if (en) hold_r <= c_q3[g];
      assign c_q3[g+1] = hold_r;
    end
  endgenerate

  ctx_t ctx7; logic nx7, ny7, zero7;
  assign {ctx7, nx7, ny7, zero7} = c_q3[L_TRIM];

  // output stage: apply signed offsets
  logic [COORD_W-1:0] sax, say, sbx, sby;
  assign sax = nx7 ? -COORD_W'(oax) : COORD_W'(oax);
  assign say = ny7 ? -COORD_W'(oay) : COORD_W'(oay);
  assign sbx = nx7 ? -COORD_W'(obx) : COORD_W'(obx);
  assign sby = ny7 ? -COORD_W'(oby) : COORD_W'(oby);

  bond_out_t out_r;
  always_ff @(posedge clk) begin
    if (en) begin
      if (ctx7.clip && !zero7) begin
        out_r.start_x <= ctx7.b.first_x + sax;
        out_r.start_y <= ctx7.b.first_y + say;
        out_r.end_x   <= ctx7.b.second_x - sbx;
        out_r.end_y   <= ctx7.b.second_y - sby;
      end else begin
        out_r.start_x <= ctx7.b.first_x;
        out_r.start_y <= ctx7.b.first_y;
        out_r.end_x   <= ctx7.b.second_x;
        out_r.end_y   <= ctx7.b.second_y;
      end
    end
  end

  assign out_ch.valid = vld_r[LAT-1];
  assign out_ch.data  = out_r;

endmodule
`default_nettype wire
